@@ rtl/rcfr_pkg.sv @@
// ============================================================================
// rcfr_pkg
// Shared types and constants of the radio-control link frame receiver.
// ============================================================================
package rcfr_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 64;
   localparam int CHANNEL_COUNT_DEF   = 16;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_SYNC_BYTE     = 2'd0;
   localparam logic [1:0] REG_CHANNELS_TYPE = 2'd1;
   localparam logic [1:0] REG_STATS_TYPE    = 2'd2;
   localparam logic [1:0] REG_LINK_TIMEOUT  = 2'd3;

   localparam logic [7:0]  SYNC_BYTE_RST     = 8'd200;
   localparam logic [7:0]  CHANNELS_TYPE_RST = 8'd22;
   localparam logic [7:0]  STATS_TYPE_RST    = 8'd20;
   localparam logic [15:0] LINK_TIMEOUT_RST  = 16'd500;

   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_STATS   = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [7:0] CRC_POLY       = 8'hD5;
   localparam int         CHAN_MIN_TLEN  = 23;
   localparam int         STATS_MIN_TLEN = 11;
   localparam int         MIN_LEN        = 2;
   localparam int         CHANNEL_BITS   = 11;
   localparam int         PAYLOAD_START  = 3;

   typedef struct packed {
      logic [7:0]  sync_byte;
      logic [7:0]  channels_frame_type;
      logic [7:0]  stats_frame_type;
      logic [15:0] link_timeout_ms;
   } cfg_type;

endpackage

@@ rtl/rc_link_frame_receiver.sv @@
// ============================================================================
// rc_link_frame_receiver
// Radio-control serial frame receiver with CRC-8 check and channel unpacking.
//
// Each input item is either a received serial byte or a link status query,
// both with a millisecond timestamp. Bytes are hunted for the sync value,
// length checked, written to a frame buffer RAM and run through a CRC-8.
// A byte that does not end a frame does not stall the input. A good
// channel frame stalls the input while a sequencer reads three buffer
// bytes per channel from the RAM (one read port, registered read) in
// states RD0 to RD3, then loads each channel item in state OUT.
// A statistics frame or a query gives one item through state EMIT.
// Every item leaves through an output register that holds while rsp_stall
// is high; the block keeps req_stall high until its result is loaded there.
// Reset returns the receiver to hunting, sets failsafe and clears the frame
// count, timestamp and link statistics. The buffer is not cleared, since
// every entry read belongs to the current frame.
// ============================================================================
module rc_link_frame_receiver
   import rcfr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
   parameter int CHANNEL_COUNT   = CHANNEL_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [7:0]            req_rx_byte,
   input  logic [31:0]           req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [3:0]            rsp_channel_index,
   output logic [10:0]           rsp_channel_value,
   output logic signed [8:0]     rsp_rssi_dbm,
   output logic [7:0]            rsp_link_quality,
   output logic                  rsp_link_up,
   output logic                  rsp_failsafe,
   output logic [31:0]           rsp_frame_count,
   output logic [31:0]           rsp_last_frame_ms,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int AW = $clog2(MAX_FRAME_BYTES);
   localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam logic [7:0]    LEN_MAX   = 8'(MAX_FRAME_BYTES - 2);
   localparam logic [7:0]    LEN_MIN   = 8'(MIN_LEN);
   localparam logic [AW-1:0] CHAN_LEN  = AW'(CHAN_MIN_TLEN);
   localparam logic [AW-1:0] STATS_LEN = AW'(STATS_MIN_TLEN);
   localparam logic [CW-1:0] CH_LAST   = CW'(CHANNEL_COUNT - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_OUT
   } state_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   cfg_type cfg;

   rcfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   state_type       state_ff;
   logic [AW-1:0]   pos_ff;
   logic [AW-1:0]   frame_len_ff;
   logic [7:0]      crc_ff;
   logic [7:0]      type_ff;
   logic [7:0]      rssi_byte_ff;
   logic [7:0]      qual_byte_ff;
   logic            failsafe_ff;
   logic [31:0]     last_good_ff;
   logic [31:0]     good_frames_ff;
   logic [8:0]      rssi_ff;
   logic [7:0]      quality_ff;
   logic [31:0]     now_ff;
   logic [1:0]      emit_kind_ff;
   logic [CW-1:0]   ch_ff;
   logic [7:0]      off_ff;
   logic [23:0]     word_ff;

   logic            rsp_valid_ff;
   logic [1:0]      kind_ff;
   logic [3:0]      index_ff;
   logic [10:0]     value_ff;
   logic [8:0]      rssi_out_ff;
   logic [7:0]      quality_out_ff;
   logic            link_up_ff;
   logic            failsafe_out_ff;
   logic [31:0]     count_out_ff;
   logic [31:0]     last_ms_out_ff;
   logic            last_ff;

   logic            accept;
   logic            out_free;
   logic            out_load;
   logic [7:0]      crc_in;
   logic            frame_end;
   logic            ram_we;
   logic [AW-1:0]   ram_raddr;
   logic [AW-1:0]   rd_base;
   logic [7:0]      ram_rdata;
   logic [31:0]     age;
   logic            link_up_now;
   logic [10:0]     chan_value;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == ST_EMIT || state_ff == ST_OUT) && out_free;
   assign crc_in    = crc8_step((pos_ff == AW'(2)) ? 8'd0 : crc_ff, req_rx_byte);
   assign frame_end = (pos_ff == AW'(frame_len_ff + AW'(1)));
   assign ram_we    = accept && (req_cmd == CMD_BYTE) && (pos_ff >= AW'(2));
   assign rd_base   = AW'(PAYLOAD_START) + AW'(off_ff >> 3);
   assign age       = now_ff - last_good_ff;
   assign link_up_now = !failsafe_ff && (last_good_ff != 32'd0) &&
                        (age <= {16'd0, cfg.link_timeout_ms});
   assign chan_value = CHANNEL_BITS'(word_ff >> off_ff[2:0]);

   always_comb begin
      case (state_ff)
         ST_RD1:  ram_raddr = AW'(rd_base + AW'(1));
         ST_RD2:  ram_raddr = AW'(rd_base + AW'(2));
         default: ram_raddr = rd_base;
      endcase
   end

   rcfr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_FRAME_BYTES)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (pos_ff),
      .wdata (req_rx_byte),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pos_ff         <= '0;
         frame_len_ff   <= '0;
         failsafe_ff    <= 1'b1;
         last_good_ff   <= '0;
         good_frames_ff <= '0;
         rssi_ff        <= '0;
         quality_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_cmd == CMD_QUERY) begin
                     now_ff       <= req_now_ms;
                     emit_kind_ff <= KIND_STATUS;
                     state_ff     <= ST_EMIT;
                  end else if (pos_ff == AW'(0)) begin
                     if (req_rx_byte == cfg.sync_byte) begin
                        pos_ff <= AW'(1);
                     end
                  end else if (pos_ff == AW'(1)) begin
                     if (req_rx_byte < LEN_MIN || req_rx_byte > LEN_MAX) begin
                        pos_ff <= '0;
                     end else begin
                        frame_len_ff <= AW'(req_rx_byte);
                        pos_ff       <= AW'(2);
                     end
                  end else begin
                     crc_ff <= crc_in;
                     if (pos_ff == AW'(2)) begin
                        type_ff <= req_rx_byte;
                     end
                     if (pos_ff == AW'(3)) begin
                        rssi_byte_ff <= req_rx_byte;
                     end
                     if (pos_ff == AW'(5)) begin
                        qual_byte_ff <= req_rx_byte;
                     end
                     if (frame_end) begin
                        pos_ff <= '0;
                        if (crc_ff == req_rx_byte) begin
                           if (type_ff == cfg.channels_frame_type &&
                               frame_len_ff > CHAN_LEN) begin
                              now_ff         <= req_now_ms;
                              last_good_ff   <= req_now_ms;
                              failsafe_ff    <= 1'b0;
                              good_frames_ff <= good_frames_ff + 32'd1;
                              ch_ff          <= '0;
                              off_ff         <= '0;
                              state_ff       <= ST_RD0;
                           end else if (type_ff == cfg.stats_frame_type &&
                                        frame_len_ff > STATS_LEN) begin
                              now_ff       <= req_now_ms;
                              rssi_ff      <= 9'd0 - {rssi_byte_ff[7], rssi_byte_ff};
                              quality_ff   <= qual_byte_ff;
                              if (qual_byte_ff == 8'd0) begin
                                 failsafe_ff <= 1'b1;
                              end
                              emit_kind_ff <= KIND_STATS;
                              state_ff     <= ST_EMIT;
                           end
                        end
                     end else begin
                        pos_ff <= AW'(pos_ff + AW'(1));
                     end
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  kind_ff      <= emit_kind_ff;
                  index_ff     <= '0;
                  value_ff     <= '0;
                  last_ff      <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_RD0: begin
               state_ff <= ST_RD1;
            end
            ST_RD1: begin
               word_ff[7:0] <= ram_rdata;
               state_ff     <= ST_RD2;
            end
            ST_RD2: begin
               word_ff[15:8] <= ram_rdata;
               state_ff      <= ST_RD3;
            end
            ST_RD3: begin
               word_ff[23:16] <= ram_rdata;
               state_ff       <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  kind_ff      <= KIND_CHANNEL;
                  index_ff     <= 4'(ch_ff);
                  value_ff     <= chan_value;
                  last_ff      <= (ch_ff == CH_LAST);
                  if (ch_ff == CH_LAST) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     ch_ff    <= CW'(ch_ff + CW'(1));
                     off_ff   <= 8'(off_ff + 8'(CHANNEL_BITS));
                     state_ff <= ST_RD0;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rssi_out_ff     <= rssi_ff;
         quality_out_ff  <= quality_ff;
         link_up_ff      <= link_up_now;
         failsafe_out_ff <= failsafe_ff;
         count_out_ff    <= good_frames_ff;
         last_ms_out_ff  <= last_good_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_channel_index = index_ff;
   assign rsp_channel_value = value_ff;
   assign rsp_rssi_dbm      = rssi_out_ff;
   assign rsp_link_quality  = quality_out_ff;
   assign rsp_link_up       = link_up_ff;
   assign rsp_failsafe      = failsafe_out_ff;
   assign rsp_frame_count   = count_out_ff;
   assign rsp_last_frame_ms = last_ms_out_ff;
   assign rsp_last          = last_ff;

endmodule

@@ rtl/rcfr_ram.sv @@
// ============================================================================
// rcfr_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
module rcfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/rcfr_csr.sv @@
// ============================================================================
// rcfr_csr
// Configuration registers of the frame receiver behind an APB-style port.
// ============================================================================
module rcfr_csr
   import rcfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic [1:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[3:2];
   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte           <= SYNC_BYTE_RST;
         cfg_ff.channels_frame_type <= CHANNELS_TYPE_RST;
         cfg_ff.stats_frame_type    <= STATS_TYPE_RST;
         cfg_ff.link_timeout_ms     <= LINK_TIMEOUT_RST;
      end else if (wr_en) begin
         case (reg_index)
            REG_SYNC_BYTE:     cfg_ff.sync_byte           <= pwdata[7:0];
            REG_CHANNELS_TYPE: cfg_ff.channels_frame_type <= pwdata[7:0];
            REG_STATS_TYPE:    cfg_ff.stats_frame_type    <= pwdata[7:0];
            REG_LINK_TIMEOUT:  cfg_ff.link_timeout_ms     <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_SYNC_BYTE:     prdata = {24'd0, cfg_ff.sync_byte};
         REG_CHANNELS_TYPE: prdata = {24'd0, cfg_ff.channels_frame_type};
         REG_STATS_TYPE:    prdata = {24'd0, cfg_ff.stats_frame_type};
         REG_LINK_TIMEOUT:  prdata = {16'd0, cfg_ff.link_timeout_ms};
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for rc_link_frame_receiver
// A short table of hand-picked bytes and queries runs first, covering bad
// length bytes, a query inside a frame and a statistics frame with quality
// zero. Random frames follow under several register settings: channel and
// statistics frames, bad CRCs, short frames, foreign types, noise and
// queries. Every result is compared with a cycle-free model of the receiver.
// ----------------------------------------------------------------------------
module testbench;
   import rcfr_pkg::*;

   localparam int SETTLE_CYCLES   = 120;
   localparam int QUIET_LIMIT     = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_ITEMS     = 90;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  chan_idx;
      logic [10:0] chan_value;
      logic [8:0]  rssi;
      logic [7:0]  quality;
      logic        up;
      logic        fs;
      logic [31:0] count;
      logic [31:0] last_ms;
      logic        last;
   } rc_result_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx;
      logic [31:0] ms;
      logic       crc;
      logic       typed;
      rc_result_type want;
   } step_row_type;

   localparam rc_result_type NO_RESULT = '0;
   localparam rc_result_type AT_RESET  =
      '{KIND_STATUS, 4'd0, 11'd0, 9'd0, 8'd0, 1'b0, 1'b1, 32'd0, 32'd0, 1'b1};
   localparam rc_result_type STATS_Q0  =
      '{KIND_STATS, 4'd0, 11'd0, 9'd128, 8'd0, 1'b0, 1'b1, 32'd0, 32'd0, 1'b1};

   localparam step_row_type DIRECTED [27] = '{
      '{CMD_QUERY, 8'h00, 32'd0,          1'b0, 1'b1, AT_RESET},
      '{CMD_QUERY, 8'hFF, 32'hFFFF_FFFF,  1'b0, 1'b1, AT_RESET},
      '{CMD_BYTE,  8'h00, 32'd1,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'hFF, 32'd2,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  SYNC_BYTE_RST, 32'd3,  1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  SYNC_BYTE_RST, 32'd3,  1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  SYNC_BYTE_RST, 32'd3,  1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'd0,  32'd4,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  SYNC_BYTE_RST, 32'd4,  1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'd1,  32'd4,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  SYNC_BYTE_RST, 32'd4,  1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'd63, 32'd4,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  SYNC_BYTE_RST, 32'd5,  1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'd12, 32'd5,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  STATS_TYPE_RST, 32'd5, 1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'h80, 32'd5,          1'b0, 1'b0, NO_RESULT},
      '{CMD_QUERY, 8'hFF, 32'd5,          1'b0, 1'b1, AT_RESET},
      '{CMD_BYTE,  8'h55, 32'd6,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'h00, 32'd6,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'hFF, 32'd6,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'h00, 32'd7,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'hAA, 32'd7,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'h01, 32'd7,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'hFE, 32'd8,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'h7F, 32'd8,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'h80, 32'd8,          1'b0, 1'b0, NO_RESULT},
      '{CMD_BYTE,  8'h00, 32'd9,          1'b1, 1'b1, STATS_Q0}
   };

   logic clock;
   logic reset = 1'b1;

   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic        req_cmd     = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic [31:0] req_now_ms  = 32'h0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_kind;
   logic [3:0]        rsp_channel_index;
   logic [10:0]       rsp_channel_value;
   logic signed [8:0] rsp_rssi_dbm;
   logic [7:0]        rsp_link_quality;
   logic              rsp_link_up;
   logic              rsp_failsafe;
   logic [31:0]       rsp_frame_count;
   logic [31:0]       rsp_last_frame_ms;
   logic              rsp_last;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   rc_link_frame_receiver u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_rx_byte       (req_rx_byte),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_rssi_dbm      (rsp_rssi_dbm),
      .rsp_link_quality  (rsp_link_quality),
      .rsp_link_up       (rsp_link_up),
      .rsp_failsafe      (rsp_failsafe),
      .rsp_frame_count   (rsp_frame_count),
      .rsp_last_frame_ms (rsp_last_frame_ms),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // Receiver model state and its copy of the registers.
   cfg_type     cfg_now = '{SYNC_BYTE_RST, CHANNELS_TYPE_RST, STATS_TYPE_RST,
                            LINK_TIMEOUT_RST};
   int          rx_pos = 0;
   int          rx_len = 0;
   logic [7:0]  frame_buf [MAX_FRAME_BYTES_DEF];
   logic        fs_flag = 1'b1;
   logic [31:0] last_good_ms = 32'h0;
   logic [31:0] good_count = 32'h0;
   logic [8:0]  rssi_q = 9'h0;
   logic [7:0]  quality_q = 8'h0;

   rc_result_type due_results [$];
   int          errors = 0;
   int          sent = 0;
   bit          calm = 1'b0;
   int          hold_off = 0;
   logic [31:0] stamp_ms = 32'h0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
      logic [7:0] r;
      r = c ^ b;
      for (int k = 0; k < 8; k++)
         r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      return r;
   endfunction

   function automatic void push_result(input logic [1:0] kind, input logic [3:0] idx,
                                       input logic [10:0] value, input logic [31:0] now,
                                       input logic last);
      rc_result_type r;
      r.kind       = kind;
      r.chan_idx   = idx;
      r.chan_value = value;
      r.rssi       = rssi_q;
      r.quality    = quality_q;
      r.up         = !fs_flag && last_good_ms != 0 &&
                     (now - last_good_ms) <= {16'h0, cfg_now.link_timeout_ms};
      r.fs         = fs_flag;
      r.count      = good_count;
      r.last_ms    = last_good_ms;
      r.last       = last;
      due_results.push_back(r);
   endfunction

   function automatic void decode_item(input logic c, input logic [7:0] b,
                                       input logic [31:0] now);
      logic [7:0]        crc;
      logic [23:0]       w;
      logic [10:0]       vals [CHANNEL_COUNT_DEF];
      logic signed [8:0] sr;
      int                tlen, off, bi;
      if (c == CMD_QUERY) begin
         push_result(KIND_STATUS, 4'd0, 11'd0, now, 1'b1);
         return;
      end
      if (rx_pos == 0) begin
         if (b == cfg_now.sync_byte) begin
            frame_buf[0] = b;
            rx_pos = 1;
         end
         return;
      end
      if (rx_pos == 1) begin
         if (b < MIN_LEN || b > MAX_FRAME_BYTES_DEF - 2) begin
            rx_pos = 0;
            return;
         end
         rx_len = b;
         frame_buf[1] = b;
         rx_pos = 2;
         return;
      end
      frame_buf[rx_pos] = b;
      rx_pos++;
      if (rx_pos < rx_len + 2) return;
      rx_pos = 0;
      tlen = rx_len - 1;
      crc = 8'h00;
      for (int i = 0; i < tlen; i++) crc = crc8_step(crc, frame_buf[2 + i]);
      if (crc != frame_buf[rx_len + 1]) return;
      if (frame_buf[2] == cfg_now.channels_frame_type && tlen >= CHAN_MIN_TLEN) begin
         for (int ch = 0; ch < CHANNEL_COUNT_DEF; ch++) begin
            off = CHANNEL_BITS * ch;
            bi = PAYLOAD_START + off / 8;
            w = {frame_buf[bi + 2], frame_buf[bi + 1], frame_buf[bi]};
            vals[ch] = 11'(w >> (off % 8));
         end
         last_good_ms = now;
         fs_flag = 1'b0;
         good_count = good_count + 1;
         for (int ch = 0; ch < CHANNEL_COUNT_DEF; ch++)
            push_result(KIND_CHANNEL, 4'(ch), vals[ch], now,
                        ch == CHANNEL_COUNT_DEF - 1);
      end else if (frame_buf[2] == cfg_now.stats_frame_type && tlen >= STATS_MIN_TLEN) begin
         sr = $signed({frame_buf[3][7], frame_buf[3]});
         rssi_q = 9'(-sr);
         quality_q = frame_buf[5];
         if (quality_q == 8'h00) fs_flag = 1'b1;
         push_result(KIND_STATS, 4'd0, 11'd0, now, 1'b1);
      end
   endfunction

   function automatic int pause_len();
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic [31:0] next_ms();
      case ($urandom_range(0, 15))
         0: stamp_ms = $urandom();
         1: stamp_ms = 32'h0;
         2: stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
         3: stamp_ms = stamp_ms + $urandom_range(60000, 70000);
         4, 5, 6, 7: stamp_ms = stamp_ms + $urandom_range(0, 600);
         default: stamp_ms = stamp_ms + $urandom_range(0, 30);
      endcase
      return stamp_ms;
   endfunction

   function automatic void cmp_field(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   task automatic send_item(input logic c, input logic [7:0] b, input logic [31:0] ms,
                            input bit counted);
      int gap;
      gap = pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= c;
      req_rx_byte <= b;
      req_now_ms  <= ms;
      do @(posedge clock); while (req_stall);
      decode_item(c, b, ms);
      if (counted) sent++;
   endtask

   task automatic req_idle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_idle();
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_frame(input logic [7:0] ftype, input int len, input bit corrupt,
                             input bit mid_query, input bit zero_quality);
      logic [7:0] line [$];
      logic [7:0] crc;
      int         qpos;
      line.push_back(cfg_now.sync_byte);
      line.push_back(8'(len));
      line.push_back(ftype);
      for (int i = 0; i < len - 2; i++) line.push_back(8'($urandom_range(0, 255)));
      if (zero_quality && line.size() > 5) line[5] = 8'h00;
      crc = 8'h00;
      for (int i = 2; i < line.size(); i++) crc = crc8_step(crc, line[i]);
      if (corrupt) crc = crc ^ 8'(1 << $urandom_range(0, 7));
      line.push_back(crc);
      qpos = mid_query ? $urandom_range(1, line.size() - 1) : -1;
      for (int i = 0; i < line.size(); i++) begin
         if (i == qpos) send_item(CMD_QUERY, 8'($urandom()), next_ms(), 1'b1);
         send_item(CMD_BYTE, line[i], next_ms(), 1'b1);
      end
   endtask

   task automatic play_sequence();
      int pick;
      pick = $urandom_range(0, 15);
      case (pick)
         0, 1, 2, 3, 4, 5:
            send_frame(cfg_now.channels_frame_type,
                       ($urandom_range(0, 7) == 0) ? $urandom_range(24, 62) : 24,
                       1'b0, 1'b0, 1'b0);
         6, 7, 8:
            send_frame(cfg_now.stats_frame_type,
                       ($urandom_range(0, 7) == 0) ? 62 : $urandom_range(12, 20),
                       1'b0, 1'b0, $urandom_range(0, 3) == 0);
         9:
            if ($urandom_range(0, 1) != 0)
               send_frame(cfg_now.channels_frame_type, 24, 1'b1, 1'b0, 1'b0);
            else
               send_frame(cfg_now.stats_frame_type, 12, 1'b1, 1'b0, 1'b0);
         10:
            send_frame(cfg_now.channels_frame_type, $urandom_range(2, 23),
                       1'b0, 1'b0, 1'b0);
         11:
            send_frame(8'($urandom()), $urandom_range(2, 16), 1'b0, 1'b0, 1'b0);
         12:
            send_item(CMD_QUERY, 8'($urandom()), next_ms(), 1'b1);
         13:
            repeat ($urandom_range(1, 4))
               send_item(CMD_BYTE, 8'($urandom()), next_ms(), 1'b0);
         14: begin
            send_item(CMD_BYTE, cfg_now.sync_byte, next_ms(), 1'b1);
            case ($urandom_range(0, 2))
               0: send_item(CMD_BYTE, 8'd0, next_ms(), 1'b1);
               1: send_item(CMD_BYTE, 8'd1, next_ms(), 1'b1);
               default: send_item(CMD_BYTE, 8'($urandom_range(63, 255)), next_ms(), 1'b1);
            endcase
         end
         default:
            send_frame(cfg_now.channels_frame_type, 24, 1'b0, 1'b1, 1'b0);
      endcase
   endtask

   task automatic run_phase(input int target);
      calm = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < target) play_sequence();
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      logic [31:0] mask;
      logic [31:0] got;
      mask = (idx == REG_LINK_TIMEOUT) ? 32'h0000_FFFF : 32'h0000_00FF;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= (val & mask) | (32'($urandom()) & ~mask);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_SYNC_BYTE:     cfg_now.sync_byte           = val[7:0];
         REG_CHANNELS_TYPE: cfg_now.channels_frame_type = val[7:0];
         REG_STATS_TYPE:    cfg_now.stats_frame_type    = val[7:0];
         default:           cfg_now.link_timeout_ms     = val[15:0];
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      cmp_field("prdata", val & mask, got);
      @(posedge clock);
   endtask

   task automatic apply_cfg(input cfg_type c);
      csr_write(REG_SYNC_BYTE, {24'h0, c.sync_byte});
      csr_write(REG_CHANNELS_TYPE, {24'h0, c.channels_frame_type});
      csr_write(REG_STATS_TYPE, {24'h0, c.stats_frame_type});
      csr_write(REG_LINK_TIMEOUT, {16'h0, c.link_timeout_ms});
   endtask

   // Result side: one draw of stall cycles per accepted item, plus the long hold-off.
   initial begin
      int hold;
      rc_result_type want;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("result item arrived with nothing expected");
               errors++;
            end else begin
               want = due_results.pop_front();
               cmp_field("kind", want.kind, rsp_kind);
               cmp_field("channel_index", want.chan_idx, rsp_channel_index);
               cmp_field("channel_value", want.chan_value, rsp_channel_value);
               cmp_field("rssi_dbm", want.rssi, $unsigned(rsp_rssi_dbm));
               cmp_field("link_quality", want.quality, rsp_link_quality);
               cmp_field("link_up", want.up, rsp_link_up);
               cmp_field("failsafe", want.fs, rsp_failsafe);
               cmp_field("frame_count", want.count, rsp_frame_count);
               cmp_field("last_frame_ms", want.last_ms, rsp_last_frame_ms);
               cmp_field("last", want.last, rsp_last);
            end
            hold = pause_len();
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_stall <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      step_row_type row;
      logic [7:0]   b;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < $size(DIRECTED); i++) begin
         row = DIRECTED[i];
         b = row.rx;
         if (row.crc) begin
            b = 8'h00;
            for (int k = 2; k <= rx_len; k++) b = crc8_step(b, frame_buf[k]);
         end
         send_item(row.cmd, b, row.ms, 1'b1);
         if (row.typed) begin
            void'(due_results.pop_back());
            due_results.push_back(row.want);
         end
      end

      run_phase(PHASE_ITEMS);

      settle();
      apply_cfg('{8'h00, 8'hFF, 8'h00, 16'h0000});
      run_phase(PHASE_ITEMS / 2);
      settle();
      run_phase(PHASE_ITEMS / 2);

      settle();
      apply_cfg('{8'hFF, 8'h00, 8'h00, 16'hFFFF});
      // The result side holds off while two channel frames are offered.
      hold_off = HOLD_OFF_CYCLES;
      sent = 0;
      send_frame(cfg_now.channels_frame_type, 24, 1'b0, 1'b0, 1'b0);
      send_frame(cfg_now.channels_frame_type, 24, 1'b0, 1'b0, 1'b0);
      run_phase(PHASE_ITEMS - 52);

      settle();
      apply_cfg('{8'($urandom()), 8'($urandom()), 8'($urandom()),
                  16'($urandom_range(0, 2000))});
      run_phase(PHASE_ITEMS);

      settle();
      apply_cfg('{SYNC_BYTE_RST, CHANNELS_TYPE_RST, STATS_TYPE_RST, LINK_TIMEOUT_RST});
      run_phase(PHASE_ITEMS);

      settle();
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/rcfr_pkg.sv
rtl/rcfr_ram.sv
rtl/rcfr_csr.sv
rtl/rc_link_frame_receiver.sv
bench/testbench.sv
